// ===== src/dxtd_pkg.sv =====
// Shared types, register codes and constant-divide helpers for the DXT block decoder.
// No dependencies; every other file in src uses it.
`timescale 1ns / 1ps

package dxtd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OUT_DEPTH   = 4;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 8'd2;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  localparam logic [2:0] DIM_MAX = 3'd4;

  localparam logic [9:0]  RECIP3 = 10'd683;
  localparam logic [13:0] RECIP7 = 14'd9363;
  localparam logic [13:0] RECIP5 = 14'd13108;

  typedef enum logic [1:0] {
    AOP_DIRECT,
    AOP_DIV7,
    AOP_DIV5
  } alpha_op_e;

  typedef struct packed {
    logic [1:0] fmt;
    logic [1:0] last_col;
    logic [1:0] last_row;
  } cfg_t;

  typedef struct packed {
    logic [3:0][2:0][7:0] pal;
    logic [31:0]          cidx;
    logic [63:0]          aw;
    logic [1:0]           fmt;
  } blk_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] col;
    logic [1:0] row;
    logic       last;
  } texel_t;

  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [19:0] p;
    p = {10'd0, v} * {10'd0, RECIP3};
    return p[18:11];
  endfunction

  function automatic logic [2:0] clamp_dim(input logic [2:0] v);
    logic [2:0] r;
    if (v == 3'd0) begin
      r = 3'd1;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== src/dxt_block_decoder.sv =====
// DXT1/DXT3/DXT5 block decoder, top level: configuration registers, front end,
// descriptor queue and texel engine. Uses dxtd_pkg, dxtd_front, dxtd_queue, dxtd_back.
// A pushed block flows through the front-end registers, descriptor queue, texel-engine stages and output FIFO.
// Throughput: one texel per cycle while a descriptor is queued and the output FIFO has room;
// a block holds width x height texels, 16 at 4x4, which the texel engine steps through in turn.
// Reset: format DXT1, 4x4 texels, all queues empty.
`timescale 1ns / 1ps

module dxt_block_decoder #(
  parameter int unsigned QueueDepth = dxtd_pkg::QUEUE_DEPTH,
  parameter int unsigned OutDepth   = dxtd_pkg::OUT_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [63:0]                     color_word_i,
  input  logic [63:0]                     alpha_word_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      red_o,
  output logic [7:0]                      green_o,
  output logic [7:0]                      blue_o,
  output logic [7:0]                      alpha_o,
  output logic [1:0]                      pixel_column_o,
  output logic [1:0]                      pixel_row_o,
  output logic                            last_pixel_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dxtd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dxtd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned QCntW = $clog2(QueueDepth + 1);

  logic [1:0] format_q;
  logic [2:0] width_q, height_q;
  logic       cfg_we;
  logic [2:0] w_eff, h_eff;

  dxtd_pkg::cfg_t   cfg;
  dxtd_pkg::blk_t   q_in, q_head;
  logic             q_push, q_pop, q_empty;
  logic [QCntW-1:0] q_count;
  dxtd_pkg::texel_t texel;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= dxtd_pkg::FMT_DXT1;
      width_q  <= dxtd_pkg::DIM_MAX;
      height_q <= dxtd_pkg::DIM_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        dxtd_pkg::REG_FORMAT: format_q <= cfg_data_i[1:0];
        dxtd_pkg::REG_WIDTH:  width_q  <= cfg_data_i[2:0];
        dxtd_pkg::REG_HEIGHT: height_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign w_eff = dxtd_pkg::clamp_dim(width_q);
  assign h_eff = dxtd_pkg::clamp_dim(height_q);

  always_comb begin
    cfg.fmt      = format_q;
    cfg.last_col = 2'(w_eff - 3'd1);
    cfg.last_row = 2'(h_eff - 3'd1);
  end

  dxtd_front #(
    .QDepth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .color_word_i (color_word_i),
    .alpha_word_i (alpha_word_i),
    .fmt_i        (format_q),
    .q_count_i    (q_count),
    .q_push_o     (q_push),
    .q_data_o     (q_in)
  );

  dxtd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  dxtd_back #(
    .OutDepth (OutDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_i       (q_head),
    .head_valid_i (~q_empty),
    .head_pop_o   (q_pop),
    .pop          (pop),
    .empty        (empty),
    .texel_o      (texel)
  );

  assign red_o          = texel.red;
  assign green_o        = texel.green;
  assign blue_o         = texel.blue;
  assign alpha_o        = texel.alpha;
  assign pixel_column_o = texel.col;
  assign pixel_row_o    = texel.row;
  assign last_pixel_o   = texel.last;

endmodule

// ===== src/dxtd_front.sv =====
// Front end: takes compressed blocks, registers them and builds the colour palette.
// Writes one block descriptor per transaction into the descriptor queue. Uses dxtd_pkg.
`timescale 1ns / 1ps

module dxtd_front #(
  parameter int unsigned QDepth = dxtd_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [63:0]                  color_word_i,
  input  logic [63:0]                  alpha_word_i,
  input  logic [1:0]                   fmt_i,
  input  logic [$clog2(QDepth+1)-1:0]  q_count_i,
  output logic                         q_push_o,
  output dxtd_pkg::blk_t               q_data_o
);

  localparam int unsigned CntW = $clog2(QDepth + 1);

  logic        f1v_q, f1v_d;
  logic [63:0] f1_cw_q;
  logic [63:0] f1_aw_q;
  logic [1:0]  f1_fmt_q;

  logic                 f2v_q;
  logic [2:0][7:0]      f2_e0_q, f2_e1_q;
  logic [2:0][9:0]      f2_sa_q, f2_sb_q;
  logic                 f2_four_q;
  logic [31:0]          f2_cidx_q;
  logic [63:0]          f2_aw_q;
  logic [1:0]           f2_fmt_q;

  logic [CntW+1:0] used;
  logic            accept;
  logic [15:0]     c0, c1;
  logic [2:0][7:0] e0, e1;
  logic [2:0][9:0] sa, sb;
  logic            four;

  assign used   = (CntW+2)'(q_count_i) + (CntW+2)'(f1v_q) + (CntW+2)'(f2v_q);
  assign full   = (used >= (CntW+2)'(QDepth));
  assign accept = push & ~full;
  assign f1v_d  = accept;

  assign c0 = f1_cw_q[15:0];
  assign c1 = f1_cw_q[31:16];
  assign e0[0] = {c0[15:11], 3'b000};
  assign e0[1] = {c0[10:5], 2'b00};
  assign e0[2] = {c0[4:0], 3'b000};
  assign e1[0] = {c1[15:11], 3'b000};
  assign e1[1] = {c1[10:5], 2'b00};
  assign e1[2] = {c1[4:0], 3'b000};
  assign four  = (c0 > c1) || (f1_fmt_q == dxtd_pkg::FMT_DXT3) ||
                 (f1_fmt_q == dxtd_pkg::FMT_DXT5);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (four) begin
        sa[c] = {1'b0, e0[c], 1'b0} + {2'b00, e1[c]} + 10'd1;
      end else begin
        sa[c] = {2'b00, e0[c]} + {2'b00, e1[c]} + 10'd1;
      end
      sb[c] = {2'b00, e0[c]} + {1'b0, e1[c], 1'b0} + 10'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1v_q <= 1'b0;
      f2v_q <= 1'b0;
    end else begin
      f1v_q <= f1v_d;
      f2v_q <= f1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_cw_q  <= color_word_i;
      f1_aw_q  <= alpha_word_i;
      f1_fmt_q <= fmt_i;
    end
    f2_e0_q   <= e0;
    f2_e1_q   <= e1;
    f2_sa_q   <= sa;
    f2_sb_q   <= sb;
    f2_four_q <= four;
    f2_cidx_q <= f1_cw_q[63:32];
    f2_aw_q   <= f1_aw_q;
    f2_fmt_q  <= f1_fmt_q;
  end

  always_comb begin
    q_data_o      = '0;
    q_data_o.cidx = f2_cidx_q;
    q_data_o.aw   = f2_aw_q;
    q_data_o.fmt  = f2_fmt_q;
    for (int c = 0; c < 3; c++) begin
      q_data_o.pal[0][c] = f2_e0_q[c];
      q_data_o.pal[1][c] = f2_e1_q[c];
      if (f2_four_q) begin
        q_data_o.pal[2][c] = dxtd_pkg::div3(f2_sa_q[c]);
        q_data_o.pal[3][c] = dxtd_pkg::div3(f2_sb_q[c]);
      end else begin
        q_data_o.pal[2][c] = f2_sa_q[c][8:1];
        q_data_o.pal[3][c] = 8'd0;
      end
    end
  end

  assign q_push_o = f2v_q;

endmodule

// ===== src/dxtd_queue.sv =====
// Descriptor queue between the front end and the texel engine.
// Small register FIFO of block descriptors. Uses dxtd_pkg.
`timescale 1ns / 1ps

module dxtd_queue #(
  parameter int unsigned Depth = dxtd_pkg::QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  dxtd_pkg::blk_t              data_i,
  input  logic                        pop_i,
  output dxtd_pkg::blk_t              data_o,
  output logic                        empty_o,
  output logic [$clog2(Depth+1)-1:0]  count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  dxtd_pkg::blk_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  assign do_pop  = pop_i & (count_q != '0);
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/dxtd_back.sv =====
// Texel engine: walks the head descriptor one texel per cycle while the output FIFO has
// room, decodes alpha in two stages and buffers texels in an output FIFO. Uses dxtd_pkg.
`timescale 1ns / 1ps

module dxtd_back #(
  parameter int unsigned OutDepth = dxtd_pkg::OUT_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dxtd_pkg::cfg_t    cfg_i,
  input  dxtd_pkg::blk_t    head_i,
  input  logic              head_valid_i,
  output logic              head_pop_o,
  input  logic              pop,
  output logic              empty,
  output dxtd_pkg::texel_t  texel_o
);

  localparam int unsigned PtrW = $clog2(OutDepth);
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  logic [1:0] x_q, x_d, y_q, y_d;
  logic       issue, last_col, last_blk;
  logic [CntW+1:0] used;

  logic [3:0]  pos;
  logic [1:0]  ci;
  logic [47:0] aw_hi;
  logic [5:0]  kpos;

  logic            s1v_q;
  logic [2:0][7:0] s1_rgb_q;
  logic [1:0]      s1_fmt_q;
  logic [3:0]      s1_nib_q;
  logic [2:0]      s1_k_q;
  logic [7:0]      s1_a0_q, s1_a1_q;
  logic [1:0]      s1_x_q, s1_y_q;
  logic            s1_last_q;

  logic                s2v_q;
  logic [2:0][7:0]     s2_rgb_q;
  dxtd_pkg::alpha_op_e s2_aop_q;
  logic [7:0]          s2_direct_q;
  logic [11:0]         s2_num_q;
  logic [1:0]          s2_x_q, s2_y_q;
  logic                s2_last_q;

  dxtd_pkg::alpha_op_e aop;
  logic [7:0]          direct;
  logic [11:0]         num;
  logic [3:0]          wa, wb, ca;
  logic [11:0]         pa, pb;

  logic [13:0]      recip;
  logic [25:0]      prod;
  dxtd_pkg::texel_t wtex;

  dxtd_pkg::texel_t mem_q [OutDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_pop;

  assign used  = (CntW+2)'(count_q) + (CntW+2)'(s1v_q) + (CntW+2)'(s2v_q);
  assign issue = head_valid_i & (used < (CntW+2)'(OutDepth));

  assign last_col   = (x_q == cfg_i.last_col);
  assign last_blk   = last_col & (y_q == cfg_i.last_row);
  assign head_pop_o = issue & last_blk;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (issue) begin
      if (last_col) begin
        x_d = 2'd0;
        y_d = last_blk ? 2'd0 : y_q + 2'd1;
      end else begin
        x_d = x_q + 2'd1;
      end
    end
  end

  assign pos   = {y_q, x_q};
  assign ci    = head_i.cidx[{pos, 1'b0} +: 2];
  assign aw_hi = head_i.aw[63:16];
  assign kpos  = 6'(pos) * 6'd3;

  always_ff @(posedge clk_i) begin
    s1_rgb_q  <= head_i.pal[ci];
    s1_fmt_q  <= head_i.fmt;
    s1_nib_q  <= head_i.aw[{pos, 2'b00} +: 4];
    s1_k_q    <= aw_hi[kpos +: 3];
    s1_a0_q   <= head_i.aw[7:0];
    s1_a1_q   <= head_i.aw[15:8];
    s1_x_q    <= x_q;
    s1_y_q    <= y_q;
    s1_last_q <= last_blk;
  end

  assign wa = 4'd8 - {1'b0, s1_k_q};
  assign wb = {1'b0, s1_k_q} - 4'd1;
  assign ca = (s1_a0_q > s1_a1_q) ? wa : wa - 4'd2;
  assign pa = {8'd0, ca} * {4'd0, s1_a0_q};
  assign pb = {8'd0, wb} * {4'd0, s1_a1_q};

  always_comb begin
    aop    = dxtd_pkg::AOP_DIRECT;
    direct = 8'hFF;
    num    = pa + pb;
    unique case (s1_fmt_q)
      dxtd_pkg::FMT_DXT3: begin
        direct = {s1_nib_q, s1_nib_q};
      end
      dxtd_pkg::FMT_DXT5: begin
        priority if (s1_k_q == 3'd0) begin
          direct = s1_a0_q;
        end else if (s1_k_q == 3'd1) begin
          direct = s1_a1_q;
        end else if (s1_a0_q > s1_a1_q) begin
          aop = dxtd_pkg::AOP_DIV7;
        end else if (s1_k_q == 3'd6) begin
          direct = 8'd0;
        end else if (s1_k_q == 3'd7) begin
          direct = 8'hFF;
        end else begin
          aop = dxtd_pkg::AOP_DIV5;
        end
      end
      default: begin
        direct = 8'hFF;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    s2_rgb_q    <= s1_rgb_q;
    s2_aop_q    <= aop;
    s2_direct_q <= direct;
    s2_num_q    <= num;
    s2_x_q      <= s1_x_q;
    s2_y_q      <= s1_y_q;
    s2_last_q   <= s1_last_q;
  end

  assign recip = (s2_aop_q == dxtd_pkg::AOP_DIV7) ? dxtd_pkg::RECIP7 : dxtd_pkg::RECIP5;
  assign prod  = {14'd0, s2_num_q} * {12'd0, recip};

  always_comb begin
    wtex.red   = s2_rgb_q[0];
    wtex.green = s2_rgb_q[1];
    wtex.blue  = s2_rgb_q[2];
    wtex.col   = s2_x_q;
    wtex.row   = s2_y_q;
    wtex.last  = s2_last_q;
    unique case (s2_aop_q)
      dxtd_pkg::AOP_DIV7,
      dxtd_pkg::AOP_DIV5: wtex.alpha = prod[23:16];
      default:            wtex.alpha = s2_direct_q;
    endcase
  end

  assign do_pop  = pop & (count_q != '0);
  assign empty   = (count_q == '0);
  assign texel_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (s2v_q && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!s2v_q && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= 2'd0;
      y_q      <= 2'd0;
      s1v_q    <= 1'b0;
      s2v_q    <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      x_q     <= x_d;
      y_q     <= y_d;
      s1v_q   <= issue;
      s2v_q   <= s1v_q;
      count_q <= count_d;
      if (s2v_q) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2v_q) begin
      mem_q[wr_ptr_q] <= wtex;
    end
  end

endmodule
